@@ rtl/assert_macros.svh @@
// Assertion helpers for the scorer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fms_pkg.sv @@
package fms_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_STRING_DEF  = 256;

    localparam int SCORE_BASE = 50;
    localparam int ACRO_BONUS = 10;
    localparam int SCORE_MAX  = 32767;
    localparam int SCORE_MIN  = -32768;

    // floor(x / 5) == (x * RECIP5) >> RECIP5_SHIFT for x < 16384
    localparam int RECIP5       = 13108;
    localparam int RECIP5_SHIFT = 16;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_STRING  = 1'b1;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DASH       = 8'h2D;

    function automatic logic is_up(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_low(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return is_up(c) ? (c + 8'd32) : c;
    endfunction

endpackage

@@ rtl/fuzzy_match_scorer.sv @@
// Flow: an item without a score result is taken in the idle state; the string byte marked
//   last produces its result after a match pass over the string, then for each start
//   position s a walk over the pattern steps at s with a note per run (plus a byte-wise
//   compare of a region of equal length to the recorded one), then the prefix compare.
// Throughput: one item at a time; the cost is set by the single read port of the pattern
//   memory and the two read ports of the string memory.
// Reset (aresetn low, synchronous): control state, lengths and output valid clear; the
//   pattern and string memories are not cleared.
module fuzzy_match_scorer #(
    parameter int MAX_PATTERN = fms_pkg::MAX_PATTERN_DEF,
    parameter int MAX_STRING  = fms_pkg::MAX_STRING_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [7:0]         s_char_code,
    input  logic               s_last_char,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_matched,
    output logic signed [15:0] m_score
);
    import fms_pkg::*;

    `include "assert_macros.svh"

    localparam int PLW  = $clog2(MAX_PATTERN + 1);
    localparam int SLW  = $clog2(MAX_STRING + 1);
    localparam int PAW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SAW  = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;
    localparam int AW   = ((SLW > PLW) ? SLW : PLW) + 1;
    localparam int ACW  = PLW + 4;
    localparam int TOTW = SLW + PLW;
    localparam int PFW  = PLW + 1;
    localparam int XW   = PLW + 3;
    localparam int MW   = XW + 14;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_M_ISSUE = 4'd1;
    localparam logic [3:0] ST_M_CHK   = 4'd2;
    localparam logic [3:0] ST_R_OUTER = 4'd3;
    localparam logic [3:0] ST_R_ISSUE = 4'd4;
    localparam logic [3:0] ST_R_CHK   = 4'd5;
    localparam logic [3:0] ST_R_NEXT  = 4'd6;
    localparam logic [3:0] ST_NOTE    = 4'd7;
    localparam logic [3:0] ST_C_ISSUE = 4'd8;
    localparam logic [3:0] ST_C_CHK   = 4'd9;
    localparam logic [3:0] ST_PERF    = 4'd10;
    localparam logic [3:0] ST_FINAL   = 4'd11;

    localparam logic [1:0] RET_ISSUE = 2'd0;
    localparam logic [1:0] RET_NEXT  = 2'd1;
    localparam logic [1:0] RET_PERF  = 2'd2;

    logic [7:0] pat_mem [MAX_PATTERN];
    logic [7:0] str_mem [MAX_STRING];
    logic [7:0] pat_rdata_reg, str_rdata_a_reg, str_rdata_b_reg;

    logic [3:0]      state_reg, state_next;
    logic [1:0]      ret_reg, ret_next;
    logic [PLW-1:0]  plen_reg, plen_next;
    logic            restart_reg, restart_next;
    logic [SLW-1:0]  slen_reg, slen_next;
    logic [SLW-1:0]  s_reg, s_next;
    logic [SLW-1:0]  c_reg, c_next;
    logic [PLW-1:0]  p_reg, p_next;
    logic [PLW-1:0]  i_reg, i_next;
    logic [7:0]      prev_reg, prev_next;
    logic [ACW-1:0]  acro_reg, acro_next;
    logic            matched_reg, matched_next;
    logic [PLW-1:0]  best_reg, best_next;
    logic [TOTW-1:0] total_reg, total_next;
    logic            rvalid_reg, rvalid_next;
    logic [SLW-1:0]  rlo_reg, rlo_next;
    logic [PLW-1:0]  rlen_reg, rlen_next;
    logic [PLW-1:0]  run_reg, run_next;
    logic [SLW-1:0]  cmp_a_reg, cmp_a_next;
    logic [SLW-1:0]  cmp_b_reg, cmp_b_next;
    logic [PFW-1:0]  perfect_reg, perfect_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_matched_reg, m_matched_next;
    logic [15:0]     m_score_reg, m_score_next;

    logic            pat_we, str_we;
    logic [PAW-1:0]  pat_waddr, pat_raddr;
    logic [SAW-1:0]  str_waddr, str_raddr_a, str_raddr_b;
    logic [PLW-1:0]  pat_widx;
    logic [AW-1:0]   sum_a, sum_b;
    logic [SLW-1:0]  run_diff;
    logic            same;
    logic [PLW-1:0]  best_max;
    logic [XW-1:0]   perf_x;
    logic [MW-1:0]   perf_prod;
    logic signed [31:0] sum_full;
    logic [15:0]     sat_score;
    logic            accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;
    assign m_score   = m_score_reg;

    assign pat_widx  = restart_reg ? '0 : plen_reg;
    assign pat_we    = accept && (s_cmd == CMD_PATTERN) && (pat_widx < PLW'(MAX_PATTERN));
    assign pat_waddr = pat_widx[PAW-1:0];
    assign str_we    = accept && (s_cmd == CMD_STRING) && (slen_reg < SLW'(MAX_STRING));
    assign str_waddr = slen_reg[SAW-1:0];

    assign sum_a    = AW'(cmp_a_reg) + AW'(i_reg);
    assign sum_b    = AW'(cmp_b_reg) + AW'(i_reg);
    assign run_diff = c_reg - s_reg;
    assign same     = (fold(pat_rdata_reg) == fold(str_rdata_a_reg));
    assign best_max = (run_reg > best_reg) ? run_reg : best_reg;
    assign perf_x   = XW'(run_reg) * XW'(6);
    assign perf_prod = MW'(perf_x) * MW'(RECIP5);

    always_comb begin
        pat_raddr   = p_reg[PAW-1:0];
        str_raddr_a = '0;
        str_raddr_b = sum_b[SAW-1:0];
        unique case (state_reg)
            ST_M_ISSUE: str_raddr_a = s_reg[SAW-1:0];
            ST_R_ISSUE: str_raddr_a = c_reg[SAW-1:0];
            ST_C_ISSUE: str_raddr_a = sum_a[SAW-1:0];
            default:    str_raddr_a = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= s_char_code;
        end
        pat_rdata_reg <= pat_mem[pat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (str_we) begin
            str_mem[str_waddr] <= s_char_code;
        end
        str_rdata_a_reg <= str_mem[str_raddr_a];
        str_rdata_b_reg <= str_mem[str_raddr_b];
    end

    always_comb begin
        sum_full = 32'(SCORE_BASE) - 32'(slen_reg) + 32'(acro_reg) + (32'(best_reg) << 1)
                 + 32'(total_reg) + 32'(perfect_reg);
        if (sum_full > 32'(SCORE_MAX)) begin
            sat_score = 16'(SCORE_MAX);
        end else if (sum_full < 32'(SCORE_MIN)) begin
            sat_score = 16'(SCORE_MIN);
        end else begin
            sat_score = sum_full[15:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        plen_next      = plen_reg;
        restart_next   = restart_reg;
        slen_next      = slen_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        prev_next      = prev_reg;
        acro_next      = acro_reg;
        matched_next   = matched_reg;
        best_next      = best_reg;
        total_next     = total_reg;
        rvalid_next    = rvalid_reg;
        rlo_next       = rlo_reg;
        rlen_next      = rlen_reg;
        run_next       = run_reg;
        cmp_a_next     = cmp_a_reg;
        cmp_b_next     = cmp_b_reg;
        perfect_next   = perfect_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_matched_next = m_matched_reg;
        m_score_next   = m_score_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_PATTERN) begin
                        plen_next    = pat_we ? (pat_widx + 1'b1) : pat_widx;
                        restart_next = s_last_char;
                    end else begin
                        restart_next = 1'b1;
                        if (str_we) begin
                            slen_next = slen_reg + 1'b1;
                        end
                        if (s_last_char) begin
                            s_next      = '0;
                            p_next      = '0;
                            acro_next   = '0;
                            best_next   = '0;
                            rvalid_next = 1'b0;
                            state_next  = ST_M_ISSUE;
                        end
                    end
                end
            end
            ST_M_ISSUE: begin
                if ((s_reg < slen_reg) && (p_reg < plen_reg)) begin
                    state_next = ST_M_CHK;
                end else if (p_reg < plen_reg) begin
                    matched_next = 1'b0;
                    perfect_next = '0;
                    state_next   = ST_FINAL;
                end else begin
                    matched_next = 1'b1;
                    s_next       = '0;
                    best_next    = '0;
                    total_next   = '0;
                    rvalid_next  = 1'b0;
                    rlo_next     = '0;
                    rlen_next    = '0;
                    perfect_next = '0;
                    state_next   = ST_R_OUTER;
                end
            end
            ST_M_CHK: begin
                if (same) begin
                    if ((s_reg == '0) || (prev_reg == CH_UNDERSCORE) || (prev_reg == CH_SLASH)
                        || (prev_reg == CH_DASH)
                        || (is_up(str_rdata_a_reg) && is_low(prev_reg))) begin
                        acro_next = acro_reg + ACW'(ACRO_BONUS);
                    end
                    p_next = p_reg + 1'b1;
                end
                prev_next  = str_rdata_a_reg;
                s_next     = s_reg + 1'b1;
                state_next = ST_M_ISSUE;
            end
            ST_R_OUTER: begin
                if (s_reg < slen_reg) begin
                    c_next     = s_reg;
                    p_next     = '0;
                    state_next = ST_R_ISSUE;
                end else begin
                    state_next = ST_PERF;
                end
            end
            ST_R_ISSUE: begin
                if ((p_reg < plen_reg) && (c_reg < slen_reg)) begin
                    state_next = ST_R_CHK;
                end else begin
                    run_next   = PLW'(run_diff);
                    ret_next   = RET_NEXT;
                    state_next = ST_NOTE;
                end
            end
            ST_R_CHK: begin
                p_next = p_reg + 1'b1;
                if (same) begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_R_ISSUE;
                end else begin
                    run_next   = PLW'(run_diff);
                    c_next     = s_reg;
                    ret_next   = RET_ISSUE;
                    state_next = ST_NOTE;
                end
            end
            ST_R_NEXT: begin
                s_next     = s_reg + 1'b1;
                state_next = ST_R_OUTER;
            end
            ST_NOTE: begin
                if ((run_reg <= PLW'(1)) || (run_reg < best_reg)) begin
                    state_next = (ret_reg == RET_ISSUE) ? ST_R_ISSUE : ST_R_NEXT;
                end else if (rvalid_reg && (rlen_reg == run_reg)) begin
                    i_next     = '0;
                    cmp_a_next = s_reg;
                    cmp_b_next = rlo_reg;
                    state_next = ST_C_ISSUE;
                end else begin
                    rvalid_next = 1'b1;
                    rlo_next    = s_reg;
                    rlen_next   = run_reg;
                    total_next  = total_reg + TOTW'(run_reg);
                    best_next   = best_max;
                    state_next  = (ret_reg == RET_ISSUE) ? ST_R_ISSUE : ST_R_NEXT;
                end
            end
            ST_C_ISSUE: begin
                if (i_reg == run_reg) begin
                    if (ret_reg == RET_PERF) begin
                        perfect_next = PFW'(perf_prod >> RECIP5_SHIFT);
                        state_next   = ST_FINAL;
                    end else begin
                        best_next  = best_max;
                        state_next = (ret_reg == RET_ISSUE) ? ST_R_ISSUE : ST_R_NEXT;
                    end
                end else begin
                    state_next = ST_C_CHK;
                end
            end
            ST_C_CHK: begin
                if (str_rdata_a_reg != str_rdata_b_reg) begin
                    if (ret_reg == RET_PERF) begin
                        state_next = ST_FINAL;
                    end else begin
                        rvalid_next = 1'b1;
                        rlo_next    = s_reg;
                        rlen_next   = run_reg;
                        total_next  = total_reg + TOTW'(run_reg);
                        best_next   = best_max;
                        state_next  = (ret_reg == RET_ISSUE) ? ST_R_ISSUE : ST_R_NEXT;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_C_ISSUE;
                end
            end
            ST_PERF: begin
                if (rvalid_reg) begin
                    run_next   = rlen_reg;
                    i_next     = '0;
                    cmp_a_next = '0;
                    cmp_b_next = rlo_reg;
                    ret_next   = RET_PERF;
                    state_next = ST_C_ISSUE;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_matched_next = matched_reg;
                    m_score_next   = matched_reg ? sat_score : '0;
                    slen_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            plen_reg    <= '0;
            restart_reg <= 1'b1;
            slen_reg    <= '0;
            m_valid_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
            best_reg    <= '0;
            rlen_reg    <= '0;
            p_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            restart_reg <= restart_next;
            slen_reg    <= slen_next;
            m_valid_reg <= m_valid_next;
            rvalid_reg  <= rvalid_next;
            best_reg    <= best_next;
            rlen_reg    <= rlen_next;
            p_reg       <= p_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg       <= ret_next;
        s_reg         <= s_next;
        c_reg         <= c_next;
        i_reg         <= i_next;
        prev_reg      <= prev_next;
        acro_reg      <= acro_next;
        matched_reg   <= matched_next;
        total_reg     <= total_next;
        rlo_reg       <= rlo_next;
        run_reg       <= run_next;
        cmp_a_reg     <= cmp_a_next;
        cmp_b_reg     <= cmp_b_next;
        perfect_reg   <= perfect_next;
        m_matched_reg <= m_matched_next;
        m_score_reg   <= m_score_next;
    end

    `ASSERT_IMPL(a_best_le_plen, aclk, aresetn, (state_reg != ST_IDLE), (best_reg <= plen_reg), "best run exceeds pattern length")
    `ASSERT_IMPL(a_region_le_best, aclk, aresetn, rvalid_reg, (rlen_reg <= best_reg), "recorded region longer than best run")
    `ASSERT_IMPL(a_match_ptr, aclk, aresetn, (state_reg == ST_M_CHK), (p_reg < plen_reg), "match pointer past pattern end")
    `ASSERT_NEXT(a_len_cleared, aclk, aresetn, ((state_reg == ST_FINAL) && (!m_valid_reg || m_ready)), ((slen_reg == '0) && m_valid_reg), "string not cleared after result")

endmodule
